### src/cbc_pkg.sv
package cbc_pkg;

   // Widths of the ROM address space and of the bus fields
   localparam int ROM_ADDRESS_BITS = 23;
   localparam int PHYS_W           = 23;
   localparam int CSR_INDEX_W      = 3;
   localparam int CSR_DATA_W       = 18;

   localparam logic [PHYS_W-1:0] ROM_ADDR_MASK =
      PHYS_W'((33'd1 << ROM_ADDRESS_BITS) - 33'd1);

   // Register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_CONTROLLER_KIND = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROM_BANK_MASK   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAM_BANK_MASK   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAM_BYTES       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_RUMBLE_PRESENT  = 3'd4;

   localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;
   localparam logic [7:0] CLOCK_SEL_LO   = 8'h08;
   localparam logic [7:0] CLOCK_SEL_HI   = 8'h0C;
   localparam logic [6:0] MBC2_RAM_PAGE  = 7'b1010000;
   localparam logic [2:0] RAM_WINDOW     = 3'b101;

   typedef enum logic [2:0] {
      KIND_PLAIN = 3'd0,
      KIND_MBC1  = 3'd1,
      KIND_MBC2  = 3'd2,
      KIND_MBC3  = 3'd3,
      KIND_MBC5  = 3'd4,
      KIND_EMPTY = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      ACT_ROM  = 3'd0,
      ACT_RAM  = 3'd1,
      ACT_NIB  = 3'd2,
      ACT_FF   = 3'd3,
      ACT_00   = 3'd4,
      ACT_WR   = 3'd5,
      ACT_NONE = 3'd6
   } action_type;

endpackage

### src/cbc_req_if.sv
interface cbc_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [15:0] bus_address;
   logic [7:0]  write_data;

   modport source (output valid, output mode, output bus_address, output write_data,
                   input ready);
   modport sink   (input valid, input mode, input bus_address, input write_data,
                   output ready);
endinterface

### src/cbc_rsp_if.sv
interface cbc_rsp_if;
   logic                           valid;
   logic                           ready;
   cbc_pkg::action_type            action;
   logic [cbc_pkg::PHYS_W-1:0]     physical_address;
   logic [7:0]                     store_data;
   logic                           ram_modified;

   modport source (output valid, output action, output physical_address,
                   output store_data, output ram_modified, input ready);
   modport sink   (input valid, input action, input physical_address,
                   input store_data, input ram_modified, output ready);
endinterface

### src/cartridge_bank_controller.sv
// Cartridge bank controller. Each req beat is one CPU bus access. Each rsp beat tells what
// the cartridge does with that access: a ROM read, a RAM read, an MBC2 nibble read, a RAM
// write, a fixed 0xFF or 0x00, or nothing. The beat also carries the translated ROM or RAM
// byte offset and the RAM-dirty flag. There are two register stages, the input register
// and the result register, with one decode stage between them that also updates the bank
// registers. A req beat goes into the input register, then through decode into the
// result register, which offers it on rsp. While rsp takes every beat, one access is
// accepted every cycle. While rsp stalls, the result register holds its beat, a full
// input register holds, and req ready drops. Write csr_* only while no beat is in flight.
module cartridge_bank_controller (
   input  logic                                clock,
   input  logic                                reset,
   cbc_req_if.sink                             req_bus,
   cbc_rsp_if.source                           rsp_bus,
   input  logic                                csr_we,
   input  logic [cbc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [cbc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   // configuration
   cbc_pkg::kind_type kind_ff;
   logic [8:0]  rom_mask_ff;
   logic [3:0]  ram_mask_ff;
   logic [17:0] ram_bytes_ff;
   logic        rumble_ff;

   // bank state
   logic [4:0] bank_low_ff,  bank_low_in;
   logic [1:0] bank_high_ff, bank_high_in;
   logic       banking_mode_ff, banking_mode_in;
   logic       ram_en_ff, ram_en_in;
   logic [8:0] wide_bank_ff, wide_bank_in;
   logic [7:0] ram_sel_ff, ram_sel_in;
   logic       dirty_ff, dirty_in;

   // input stage
   logic        s1_valid_ff, s1_valid_in;
   logic        s1_mode_ff;
   logic [15:0] s1_addr_ff;
   logic [7:0]  s1_data_ff;

   // result stage
   logic                       out_valid_ff, out_valid_in;
   cbc_pkg::action_type        out_act_ff;
   logic [cbc_pkg::PHYS_W-1:0] out_addr_ff;
   logic [7:0]                 out_data_ff;
   logic                       out_dirty_ff;

   logic advance, accept, commit;

   // decode
   logic                       wr, ramwin, rom_go, ram_go;
   logic [15:0]                a;
   logic [7:0]                 d;
   logic [12:0]                roff;
   logic [4:0]                 lo;
   logic [8:0]                 rom_page;
   logic [3:0]                 ram_page;
   logic [16:0]                ram_off;
   cbc_pkg::action_type        act;
   logic [cbc_pkg::PHYS_W-1:0] phys;
   logic [7:0]                 sdata;

   assign advance       = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready = !s1_valid_ff || advance;
   assign accept        = req_bus.valid && req_bus.ready;
   assign commit        = s1_valid_ff && advance;

   assign wr     = s1_mode_ff;
   assign a      = s1_addr_ff;
   assign d      = s1_data_ff;
   assign ramwin = (a[15:13] == cbc_pkg::RAM_WINDOW);
   assign roff   = a[12:0];

   always_comb begin
      act             = wr ? cbc_pkg::ACT_NONE : cbc_pkg::ACT_FF;
      phys            = '0;
      sdata           = '0;
      rom_go          = 1'b0;
      rom_page        = '0;
      ram_go          = 1'b0;
      ram_page        = '0;
      lo              = '0;
      bank_low_in     = bank_low_ff;
      bank_high_in    = bank_high_ff;
      banking_mode_in = banking_mode_ff;
      ram_en_in       = ram_en_ff;
      wide_bank_in    = wide_bank_ff;
      ram_sel_in      = ram_sel_ff;
      dirty_in        = dirty_ff;

      unique case (kind_ff)
         cbc_pkg::KIND_PLAIN: begin
            if (!wr && !a[15]) begin
               rom_go   = 1'b1;
               rom_page = {8'd0, a[14]};
            end else if (ramwin) begin
               ram_go = 1'b1;
            end
         end
         cbc_pkg::KIND_MBC1: begin
            if (!a[15] && wr) begin
               unique case (a[14:13])
                  2'b00:   ram_en_in       = (d[3:0] == cbc_pkg::RAM_ENABLE_KEY);
                  2'b01:   bank_low_in     = d[4:0];
                  2'b10:   bank_high_in    = d[1:0];
                  default: banking_mode_in = d[0];
               endcase
            end else if (a[15:14] == 2'b00) begin
               rom_go   = 1'b1;
               rom_page = {2'd0, (banking_mode_ff ? bank_high_ff : 2'd0), 5'd0}
                          & rom_mask_ff;
            end else if (!a[15]) begin
               lo       = (bank_low_ff == 5'd0) ? 5'd1 : bank_low_ff;
               rom_go   = 1'b1;
               rom_page = {2'd0, bank_high_ff, lo} & rom_mask_ff;
            end else if (ramwin && ram_en_ff) begin
               ram_go   = 1'b1;
               ram_page = {2'd0, (banking_mode_ff ? bank_high_ff : 2'd0)} & ram_mask_ff;
            end
         end
         cbc_pkg::KIND_MBC2: begin
            if (a[15:14] == 2'b00 && wr) begin
               if (!a[8])
                  ram_en_in = (d[3:0] == cbc_pkg::RAM_ENABLE_KEY);
               else
                  wide_bank_in = (d[3:0] == 4'd0) ? 9'd1 : {5'd0, d[3:0]};
            end else if (a[15:14] == 2'b00) begin
               rom_go = 1'b1;
            end else if (!a[15]) begin
               if (!wr) begin
                  rom_go   = 1'b1;
                  rom_page = ((wide_bank_ff == 9'd0) ? 9'd1 : wide_bank_ff) & rom_mask_ff;
               end
            end else if (a[15:9] == cbc_pkg::MBC2_RAM_PAGE && ram_en_ff
                         && ram_bytes_ff != 18'd0) begin
               phys = {10'd0, roff};
               if (wr) begin
                  act      = cbc_pkg::ACT_WR;
                  sdata    = {4'd0, d[3:0]};
                  dirty_in = 1'b1;
               end else begin
                  act = cbc_pkg::ACT_NIB;
               end
            end
         end
         cbc_pkg::KIND_MBC3: begin
            if (!a[15] && wr) begin
               unique case (a[14:13])
                  2'b00:   ram_en_in    = (d[3:0] == cbc_pkg::RAM_ENABLE_KEY);
                  2'b01:   wide_bank_in = (d[6:0] == 7'd0) ? 9'd1 : {2'd0, d[6:0]};
                  2'b10:   ram_sel_in   = d;
                  default: ;
               endcase
            end else if (a[15:14] == 2'b00) begin
               rom_go = 1'b1;
            end else if (!a[15]) begin
               rom_go   = 1'b1;
               rom_page = ((wide_bank_ff == 9'd0) ? 9'd1 : wide_bank_ff) & rom_mask_ff;
            end else if (ramwin && ram_en_ff) begin
               // clock registers are a stub: reads give zero, writes drop
               if (ram_sel_ff >= cbc_pkg::CLOCK_SEL_LO
                   && ram_sel_ff <= cbc_pkg::CLOCK_SEL_HI) begin
                  if (!wr) act = cbc_pkg::ACT_00;
               end else begin
                  ram_go   = 1'b1;
                  ram_page = ram_sel_ff[3:0] & ram_mask_ff;
               end
            end
         end
         cbc_pkg::KIND_MBC5: begin
            if (!a[15] && wr) begin
               unique case (a[14:13])
                  2'b00: ram_en_in = (d[3:0] == cbc_pkg::RAM_ENABLE_KEY);
                  2'b01: begin
                     if (!a[12]) wide_bank_in = {wide_bank_ff[8], d};
                     else        wide_bank_in = {d[0], wide_bank_ff[7:0]};
                  end
                  2'b10:   ram_sel_in = rumble_ff ? {5'd0, d[2:0]} : {4'd0, d[3:0]};
                  default: ;
               endcase
            end else if (a[15:14] == 2'b00) begin
               rom_go = 1'b1;
            end else if (!a[15]) begin
               rom_go   = 1'b1;
               rom_page = wide_bank_ff & rom_mask_ff;
            end else if (ramwin && ram_en_ff) begin
               ram_go   = 1'b1;
               ram_page = ram_sel_ff[3:0] & ram_mask_ff;
            end
         end
         default: ;
      endcase

      ram_off = {ram_page, roff};

      if (rom_go) begin
         act  = cbc_pkg::ACT_ROM;
         phys = {rom_page, a[13:0]} & cbc_pkg::ROM_ADDR_MASK;
      end else if (ram_go && ({1'b0, ram_off} < ram_bytes_ff)) begin
         phys = {6'd0, ram_off};
         if (wr) begin
            act      = cbc_pkg::ACT_WR;
            sdata    = d;
            dirty_in = 1'b1;
         end else begin
            act = cbc_pkg::ACT_RAM;
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept)       s1_valid_in = 1'b1;
      else if (advance) s1_valid_in = 1'b0;
      out_valid_in = advance ? s1_valid_ff : out_valid_ff;
   end

   // control and bank state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         kind_ff          <= cbc_pkg::KIND_EMPTY;
         rom_mask_ff      <= 9'd1;
         ram_mask_ff      <= '0;
         ram_bytes_ff     <= '0;
         rumble_ff        <= 1'b0;
         bank_low_ff      <= 5'd1;
         bank_high_ff     <= '0;
         banking_mode_ff  <= 1'b0;
         ram_en_ff        <= 1'b0;
         wide_bank_ff     <= 9'd1;
         ram_sel_ff       <= '0;
         dirty_ff         <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               cbc_pkg::CSR_CONTROLLER_KIND: kind_ff <= cbc_pkg::kind_type'(csr_wdata[2:0]);
               cbc_pkg::CSR_ROM_BANK_MASK:   rom_mask_ff  <= csr_wdata[8:0];
               cbc_pkg::CSR_RAM_BANK_MASK:   ram_mask_ff  <= csr_wdata[3:0];
               cbc_pkg::CSR_RAM_BYTES:       ram_bytes_ff <= csr_wdata;
               cbc_pkg::CSR_RUMBLE_PRESENT:  rumble_ff    <= csr_wdata[0];
               default: ;
            endcase
         end
         if (commit) begin
            bank_low_ff     <= bank_low_in;
            bank_high_ff    <= bank_high_in;
            banking_mode_ff <= banking_mode_in;
            ram_en_ff       <= ram_en_in;
            wide_bank_ff    <= wide_bank_in;
            ram_sel_ff      <= ram_sel_in;
            dirty_ff        <= dirty_in;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_mode_ff <= req_bus.mode;
         s1_addr_ff <= req_bus.bus_address;
         s1_data_ff <= req_bus.write_data;
      end
      if (commit) begin
         out_act_ff   <= act;
         out_addr_ff  <= phys;
         out_data_ff  <= sdata;
         out_dirty_ff <= dirty_in;
      end
   end

   assign rsp_bus.valid            = out_valid_ff;
   assign rsp_bus.action           = out_act_ff;
   assign rsp_bus.physical_address = out_addr_ff;
   assign rsp_bus.store_data       = out_data_ff;
   assign rsp_bus.ram_modified     = out_dirty_ff;

`ifndef ASSERT_OFF
   a_dirty_sticky: assert property (@(posedge clock) disable iff (reset)
      dirty_ff |=> dirty_ff)
      else $error("dirty flag cleared without reset");

   a_write_marks_dirty: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_act_ff == cbc_pkg::ACT_WR |-> out_dirty_ff)
      else $error("RAM write beat without dirty flag");

   a_fixed_reads_clean: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_act_ff == cbc_pkg::ACT_FF || out_act_ff == cbc_pkg::ACT_00
                       || out_act_ff == cbc_pkg::ACT_NONE)
      |-> out_addr_ff == '0 && out_data_ff == '0)
      else $error("address or data set on a beat without memory access");

   a_stage_held: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_addr_ff))
      else $error("input stage dropped a stalled beat");
`endif

endmodule

### tb/cartridge_bank_controller_test.sv
`timescale 1ns / 100ps

module cartridge_bank_controller_test;

   localparam int QUIET_LIMIT = 3000;
   localparam int HOLD_CYCLES = 300;

   typedef struct {
      cbc_pkg::action_type          action;
      logic [cbc_pkg::PHYS_W-1:0]   addr;
      logic [7:0]                   data;
      logic                         dirty;
   } bus_result_type;

   // Mirror of the mapper: bank registers, configuration and the results still due.
   class mapper_model;
      logic [2:0]  kind;
      logic [8:0]  rom_mask;
      logic [3:0]  ram_mask;
      logic [17:0] ram_limit;
      logic        rumble;
      logic [4:0]  bank_lo;
      logic [1:0]  bank_hi;
      logic        bank_mode;
      logic        ram_on;
      logic [8:0]  wide_bank;
      logic [7:0]  ram_sel;
      logic        dirty;
      bus_result_type res;
      bus_result_type due_results[$];
      int          errors;
      int          accesses;
      int          action_count[7];

      function new();
         kind      = cbc_pkg::KIND_EMPTY;
         rom_mask  = 9'd1;
         ram_mask  = 4'd0;
         ram_limit = 18'd0;
         rumble    = 1'b0;
         bank_lo   = 5'd1;
         bank_hi   = 2'd0;
         bank_mode = 1'b0;
         ram_on    = 1'b0;
         wide_bank = 9'd1;
         ram_sel   = 8'd0;
         dirty     = 1'b0;
         errors    = 0;
         accesses  = 0;
         foreach (action_count[i]) action_count[i] = 0;
      endfunction

      function void set_register(logic [cbc_pkg::CSR_INDEX_W-1:0] index,
                                 logic [cbc_pkg::CSR_DATA_W-1:0] v);
         case (index)
            cbc_pkg::CSR_CONTROLLER_KIND: kind      = v[2:0];
            cbc_pkg::CSR_ROM_BANK_MASK:   rom_mask  = v[8:0];
            cbc_pkg::CSR_RAM_BANK_MASK:   ram_mask  = v[3:0];
            cbc_pkg::CSR_RAM_BYTES:       ram_limit = v;
            cbc_pkg::CSR_RUMBLE_PRESENT:  rumble    = v[0];
            default: ;
         endcase
      endfunction

      function int pending();
         return due_results.size();
      endfunction

      function void rom_read(logic [8:0] bank, logic [15:0] a);
         res.action = cbc_pkg::ACT_ROM;
         res.addr   = {bank, a[13:0]} & cbc_pkg::ROM_ADDR_MASK;
      endfunction

      // Bounds check against the RAM size, then read or store.
      function void ram_access(logic wr, int unsigned off, logic [7:0] d);
         if (ram_limit == 0 || off >= ram_limit) return;
         res.addr = off[cbc_pkg::PHYS_W-1:0];
         if (wr) begin
            res.action = cbc_pkg::ACT_WR;
            res.data   = d;
            dirty      = 1'b1;
         end else begin
            res.action = cbc_pkg::ACT_RAM;
         end
      endfunction

      function void note_access(logic wr, logic [15:0] a, logic [7:0] d);
         logic        ramwin;
         int unsigned roff;
         logic [4:0]  lo;
         ramwin     = a >= 16'hA000 && a <= 16'hBFFF;
         roff       = {16'd0, a} - 32'hA000;
         res.action = wr ? cbc_pkg::ACT_NONE : cbc_pkg::ACT_FF;
         res.addr   = '0;
         res.data   = '0;
         case (kind)
            cbc_pkg::KIND_PLAIN: begin
               if (!wr && a <= 16'h7FFF) rom_read({8'd0, a[14]}, a);
               else if (ramwin) ram_access(wr, roff, d);
            end
            cbc_pkg::KIND_MBC1: begin
               if (a <= 16'h7FFF && wr) begin
                  if (a <= 16'h1FFF) ram_on = (d[3:0] == cbc_pkg::RAM_ENABLE_KEY);
                  else if (a <= 16'h3FFF) bank_lo = d[4:0];
                  else if (a <= 16'h5FFF) bank_hi = d[1:0];
                  else bank_mode = d[0];
               end else if (a <= 16'h3FFF) begin
                  rom_read((bank_mode ? {2'b0, bank_hi, 5'b0} : 9'd0) & rom_mask, a);
               end else if (a <= 16'h7FFF) begin
                  lo = (bank_lo == 0) ? 5'd1 : bank_lo;
                  rom_read({2'b0, bank_hi, lo} & rom_mask, a);
               end else if (ramwin && ram_on) begin
                  ram_access(wr, ({2'b0, bank_mode ? bank_hi : 2'b0} & ram_mask) * 32'h2000
                                 + roff, d);
               end
            end
            cbc_pkg::KIND_MBC2: begin
               if (a <= 16'h3FFF && wr) begin
                  if (!a[8]) begin
                     ram_on = (d[3:0] == cbc_pkg::RAM_ENABLE_KEY);
                  end else begin
                     wide_bank = {5'd0, d[3:0]};
                     if (wide_bank == 0) wide_bank = 9'd1;
                  end
               end else if (a <= 16'h3FFF) begin
                  rom_read(9'd0, a);
               end else if (a <= 16'h7FFF) begin
                  if (!wr) rom_read(((wide_bank == 0) ? 9'd1 : wide_bank) & rom_mask, a);
               end else if (a[15:9] == cbc_pkg::MBC2_RAM_PAGE && ram_on && ram_limit != 0)
               begin
                  res.addr = roff[cbc_pkg::PHYS_W-1:0];
                  if (wr) begin
                     res.action = cbc_pkg::ACT_WR;
                     res.data   = {4'd0, d[3:0]};
                     dirty      = 1'b1;
                  end else begin
                     res.action = cbc_pkg::ACT_NIB;
                  end
               end
            end
            cbc_pkg::KIND_MBC3: begin
               if (a <= 16'h7FFF && wr) begin
                  if (a <= 16'h1FFF) begin
                     ram_on = (d[3:0] == cbc_pkg::RAM_ENABLE_KEY);
                  end else if (a <= 16'h3FFF) begin
                     wide_bank = {2'd0, d[6:0]};
                     if (wide_bank == 0) wide_bank = 9'd1;
                  end else if (a <= 16'h5FFF) begin
                     ram_sel = d;
                  end
               end else if (a <= 16'h3FFF) begin
                  rom_read(9'd0, a);
               end else if (a <= 16'h7FFF) begin
                  rom_read(((wide_bank == 0) ? 9'd1 : wide_bank) & rom_mask, a);
               end else if (ramwin && ram_on) begin
                  // clock registers are a stub: reads give zero, stores drop
                  if (ram_sel >= cbc_pkg::CLOCK_SEL_LO && ram_sel <= cbc_pkg::CLOCK_SEL_HI)
                  begin
                     if (!wr) res.action = cbc_pkg::ACT_00;
                  end else begin
                     ram_access(wr, (ram_sel[3:0] & ram_mask) * 32'h2000 + roff, d);
                  end
               end
            end
            cbc_pkg::KIND_MBC5: begin
               if (a <= 16'h7FFF && wr) begin
                  if (a <= 16'h1FFF) ram_on = (d[3:0] == cbc_pkg::RAM_ENABLE_KEY);
                  else if (a <= 16'h2FFF) wide_bank = {wide_bank[8], d};
                  else if (a <= 16'h3FFF) wide_bank = {d[0], wide_bank[7:0]};
                  else if (a <= 16'h5FFF) ram_sel = rumble ? {5'd0, d[2:0]} : {4'd0, d[3:0]};
               end else if (a <= 16'h3FFF) begin
                  rom_read(9'd0, a);
               end else if (a <= 16'h7FFF) begin
                  rom_read(wide_bank & rom_mask, a);
               end else if (ramwin && ram_on) begin
                  ram_access(wr, (ram_sel[3:0] & ram_mask) * 32'h2000 + roff, d);
               end
            end
            default: ;
         endcase
         res.dirty = dirty;
         due_results.push_back(res);
         accesses++;
      endfunction

      function void check_result(cbc_pkg::action_type act, logic [cbc_pkg::PHYS_W-1:0] addr,
                                 logic [7:0] data, logic mod);
         bus_result_type e;
         if (due_results.size() == 0) begin
            errors++;
            $display("%0t: result beat with no access pending: action %0d addr %h", $time,
                     act, addr);
            return;
         end
         e = due_results.pop_front();
         action_count[int'(e.action)]++;
         if (act !== e.action || addr !== e.addr || data !== e.data || mod !== e.dirty) begin
            errors++;
            $display("%0t: mismatch, expected action %0d addr %h data %h dirty %b", $time,
                     e.action, e.addr, e.data, e.dirty);
            $display("%0t:           got action %0d addr %h data %h dirty %b", $time,
                     act, addr, data, mod);
         end
      endfunction
   endclass

   logic                             clock;
   logic                             reset;
   logic                             csr_we;
   logic [cbc_pkg::CSR_INDEX_W-1:0]  csr_index;
   logic [cbc_pkg::CSR_DATA_W-1:0]   csr_wdata;

   cbc_req_if req_bus ();
   cbc_rsp_if rsp_bus ();

   cartridge_bank_controller u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   mapper_model model = new();

   bit snd_idle_on  = 1'b0;
   bit rsp_idle_on  = 1'b0;
   bit hold_request = 1'b0;
   int settings     = 0;
   int quiet_cycles = 0;

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic int idle_length();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
   endfunction

   // Receiver: random stalls, plus one long hold-off on request.
   initial begin
      int hold_left;
      int stall_left;
      hold_left     = 0;
      stall_left    = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (rsp_idle_on && $urandom_range(0, 4) == 0) stall_left = idle_length();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            model.note_access(req_bus.mode, req_bus.bus_address, req_bus.write_data);
         if (rsp_bus.valid && rsp_bus.ready)
            model.check_result(rsp_bus.action, rsp_bus.physical_address, rsp_bus.store_data,
                               rsp_bus.ram_modified);
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
         $display("cartridge_bank_controller test failed");
         $finish;
      end
   end

   task automatic send_access(input logic m, input logic [15:0] a, input logic [7:0] d);
      int gap;
      gap = (snd_idle_on && $urandom_range(0, 3) == 0) ? idle_length() : 0;
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid       <= 1'b1;
      req_bus.mode        <= m;
      req_bus.bus_address <= a;
      req_bus.write_data  <= d;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Drop valid and wait until every result has come back.
   task automatic drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (model.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [cbc_pkg::CSR_INDEX_W-1:0] index,
                                 input int unsigned value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value[cbc_pkg::CSR_DATA_W-1:0];
      model.set_register(index, value[cbc_pkg::CSR_DATA_W-1:0]);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic configure(input cbc_pkg::kind_type kind, input int unsigned rom_mask,
                            input int unsigned ram_mask, input int unsigned ram_limit,
                            input int unsigned rumble);
      drain();
      write_register(cbc_pkg::CSR_CONTROLLER_KIND, kind);
      write_register(cbc_pkg::CSR_ROM_BANK_MASK, rom_mask);
      write_register(cbc_pkg::CSR_RAM_BANK_MASK, ram_mask);
      write_register(cbc_pkg::CSR_RAM_BYTES, ram_limit);
      write_register(cbc_pkg::CSR_RUMBLE_PRESENT, rumble);
      settings++;
   endtask

   // Mostly bank-register writes and window accesses, the rest pure noise.
   task automatic pick_access(input logic [2:0] kind, output logic m, output logic [15:0] a,
                              output logic [7:0] d);
      int unsigned r;
      int unsigned region;
      r = $urandom_range(0, 99);
      m = 1'($urandom_range(0, 1));
      a = 16'($urandom_range(0, 16'hFFFF));
      d = 8'($urandom_range(0, 255));
      if (r < 25) begin
         m      = 1'b1;
         region = $urandom_range(0, 3);
         a      = 16'(region * 32'h2000 + $urandom_range(0, 16'h1FFF));
         if (region == 0 && $urandom_range(0, 9) < 7) d[3:0] = cbc_pkg::RAM_ENABLE_KEY;
         else if (region == 1 && $urandom_range(0, 2) == 0) d = 8'($urandom_range(0, 1));
         else if (region == 2 && $urandom_range(0, 1) == 1) d = 8'($urandom_range(0, 15));
      end else if (r < 45) begin
         m = ($urandom_range(0, 9) == 0);
         a = 16'($urandom_range(0, 16'h7FFF));
      end else if (r < 85) begin
         if (kind == cbc_pkg::KIND_MBC2 && $urandom_range(0, 4) != 0)
            a = 16'hA000 + 16'($urandom_range(0, 16'h1FF));
         else
            a = 16'hA000 + 16'($urandom_range(0, 16'h1FFF));
      end
   endtask

   task automatic run_phase(input cbc_pkg::kind_type kind, input int unsigned rom_mask,
                            input int unsigned ram_mask, input int unsigned ram_limit,
                            input int unsigned rumble, input int count, input bit squeeze,
                            input bit pause);
      logic        m;
      logic [15:0] a;
      logic [7:0]  d;
      configure(kind, rom_mask, ram_mask, ram_limit, rumble);
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) begin
            snd_idle_on = ($urandom_range(0, 2) != 0);
            rsp_idle_on = ($urandom_range(0, 2) != 0);
         end
         // hold the receiver off while the sender keeps pushing
         if (squeeze && i < 60) snd_idle_on = 1'b0;
         if (squeeze && i == 0) hold_request = 1'b1;
         if (pause && i == count / 2) drain();
         pick_access(kind, m, a, d);
         send_access(m, a, d);
      end
   endtask

   initial begin
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = '0;
      csr_wdata           = '0;
      req_bus.valid       = 1'b0;
      req_bus.mode        = 1'b0;
      req_bus.bus_address = '0;
      req_bus.write_data  = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // empty kind straight out of reset
      send_access(1'b0, 16'h0000, 8'h00);
      send_access(1'b1, 16'h4000, 8'hFF);

      configure(cbc_pkg::KIND_MBC1, 511, 3, 32768, 0);
      send_access(1'b0, 16'h0000, 8'h00);
      send_access(1'b0, 16'h7FFF, 8'h00);
      send_access(1'b1, 16'h2000, 8'h00);
      send_access(1'b0, 16'h4000, 8'h00);
      send_access(1'b1, 16'h0000, 8'h0A);
      send_access(1'b1, 16'h4000, 8'h03);
      send_access(1'b1, 16'h6000, 8'h01);
      send_access(1'b0, 16'h3FFF, 8'h00);
      send_access(1'b0, 16'hA000, 8'h00);
      send_access(1'b1, 16'hBFFF, 8'hFF);
      send_access(1'b0, 16'hBFFF, 8'h00);
      send_access(1'b1, 16'h2000, 8'h1F);
      send_access(1'b0, 16'h7FFF, 8'h00);
      send_access(1'b0, 16'h8000, 8'h00);
      send_access(1'b1, 16'h9FFF, 8'hFF);
      send_access(1'b0, 16'hFFFF, 8'h00);
      send_access(1'b1, 16'hC000, 8'h00);
      send_access(1'b1, 16'h0000, 8'h00);
      send_access(1'b0, 16'hA000, 8'h00);

      run_phase(cbc_pkg::KIND_PLAIN, 1, 0, 8192, 0, 140, 1'b0, 1'b1);
      run_phase(cbc_pkg::KIND_MBC1, 511, 3, 32768, 0, 140, 1'b1, 1'b0);
      run_phase(cbc_pkg::KIND_MBC1, 0, 0, 0, 1, 140, 1'b0, 1'b0);
      run_phase(cbc_pkg::KIND_MBC2, 15, 0, 512, 0, 140, 1'b0, 1'b1);
      run_phase(cbc_pkg::KIND_MBC3, 127, 3, 32768, 0, 140, 1'b0, 1'b0);
      run_phase(cbc_pkg::KIND_MBC3, 63, 15, 131072, 0, 140, 1'b1, 1'b1);
      run_phase(cbc_pkg::KIND_MBC5, 511, 15, 131072, 0, 140, 1'b0, 1'b0);
      run_phase(cbc_pkg::KIND_MBC5, 255, 7, 65536, 1, 140, 1'b0, 1'b1);
      run_phase(cbc_pkg::KIND_MBC1, 31, 3, 10000, 0, 140, 1'b0, 1'b0);
      run_phase(cbc_pkg::KIND_EMPTY, 3, 1, 16384, 0, 140, 1'b0, 1'b0);
      run_phase(cbc_pkg::KIND_MBC2, 7, 0, 0, 0, 140, 1'b0, 1'b0);
      drain();

      $display("covered %0d bus accesses over %0d register settings", model.accesses,
               settings);
      $display("results: rom %0d, ram read %0d, nibble %0d, 0xFF %0d, 0x00 %0d, %s",
               model.action_count[cbc_pkg::ACT_ROM], model.action_count[cbc_pkg::ACT_RAM],
               model.action_count[cbc_pkg::ACT_NIB], model.action_count[cbc_pkg::ACT_FF],
               model.action_count[cbc_pkg::ACT_00],
               $sformatf("store %0d, none %0d", model.action_count[cbc_pkg::ACT_WR],
                         model.action_count[cbc_pkg::ACT_NONE]));
      if (model.errors == 0 && model.pending() == 0)
         $display("cartridge_bank_controller test passed");
      else
         $display("cartridge_bank_controller test failed");
      $finish;
   end

endmodule

### cartridge_bank_controller.f
src/cbc_pkg.sv
src/cbc_req_if.sv
src/cbc_rsp_if.sv
src/cartridge_bank_controller.sv
tb/cartridge_bank_controller_test.sv
